// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/bgp_pkg.sv
// ----------------------------------------------------------------------------
// bgp_pkg
// Types and constants of the bitmap gather and pack engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bgp_pkg;

   localparam int STORE_WORDS_DEF = 1024;
   localparam int WORD_W          = 64;
   localparam int COUNT_W         = 7;
   localparam int ROW_W           = 16;
   localparam int BIT_IDX_W       = 17;
   localparam int ADDR_W          = 10;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_GATHER = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   localparam logic [1:0] MODE_RESHUFFLE = 2'd0;
   localparam logic [1:0] MODE_MERGE     = 2'd1;
   localparam logic [1:0] MODE_COLUMN    = 2'd2;

   localparam logic [2:0] REG_GATHER_MODE = 3'd0;
   localparam logic [2:0] REG_A_PRESENT   = 3'd1;
   localparam logic [2:0] REG_B_PRESENT   = 3'd2;
   localparam logic [2:0] REG_B_OFFSET    = 3'd3;
   localparam logic [2:0] REG_COLUMN_TOP  = 3'd4;

   typedef struct packed {
      logic [1:0]        op;
      logic              store_select;
      logic [ADDR_W-1:0] word_address;
      logic [WORD_W-1:0] word_data;
      logic              pick;
      logic [ROW_W-1:0]  row_index;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  packed_word;
      logic [COUNT_W-1:0] bit_count;
      logic               last;
      logic               range_error;
   } rsp_type;

   typedef struct packed {
      logic [1:0]           gather_mode;
      logic                 a_present;
      logic                 b_present;
      logic [ROW_W-1:0]     b_bit_offset;
      logic [BIT_IDX_W-1:0] column_top_rows;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic fetch;
      logic append;
      logic emit;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic acc_empty;
      logic acc_last_slot;
      logic out_free;
      logic error;
   } status_type;

endpackage

// File: rtl/bgp_csr.sv
// ----------------------------------------------------------------------------
// bgp_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgp_csr
   import bgp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GATHER_MODE: cfg_in.gather_mode     = pwdata[1:0];
            REG_A_PRESENT:   cfg_in.a_present       = pwdata[0];
            REG_B_PRESENT:   cfg_in.b_present       = pwdata[0];
            REG_B_OFFSET:    cfg_in.b_bit_offset    = pwdata[ROW_W-1:0];
            REG_COLUMN_TOP:  cfg_in.column_top_rows = pwdata[BIT_IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gather_mode     <= MODE_RESHUFFLE;
         cfg_ff.a_present       <= 1'b1;
         cfg_ff.b_present       <= 1'b1;
         cfg_ff.b_bit_offset    <= '0;
         cfg_ff.column_top_rows <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_GATHER_MODE: prdata[1:0]           = cfg_ff.gather_mode;
         REG_A_PRESENT:   prdata[0]             = cfg_ff.a_present;
         REG_B_PRESENT:   prdata[0]             = cfg_ff.b_present;
         REG_B_OFFSET:    prdata[ROW_W-1:0]     = cfg_ff.b_bit_offset;
         REG_COLUMN_TOP:  prdata[BIT_IDX_W-1:0] = cfg_ff.column_top_rows;
         default: ;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/bgp_ctrl.sv
// ----------------------------------------------------------------------------
// bgp_ctrl
// Sequencer: accepts items and steps the datapath through fetch, append
// and emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgp_ctrl
   import bgp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      last_ff;
   logic      last_in;

   always_comb begin
      state_in   = state_ff;
      last_in    = last_ff;
      req_stall  = 1'b1;
      cmd        = '0;
      cmd.last   = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_op)
                  OP_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  OP_GATHER: begin
                     cmd.fetch = 1'b1;
                     state_in  = S_FETCH;
                  end
                  OP_FLUSH: begin
                     if (!status.acc_empty) begin
                        last_in  = 1'b1;
                        state_in = S_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            cmd.append = 1'b1;
            if (status.acc_last_slot) begin
               last_in  = 1'b0;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

// File: rtl/bgp_dpath.sv
// ----------------------------------------------------------------------------
// bgp_dpath
// Bit stores, source selection, accumulator and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgp_dpath
   import bgp_pkg::*;
#(
   parameter int STORE_WORDS = STORE_WORDS_DEF
)(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload
);

   localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam logic [BIT_IDX_W:0] DEPTH = (BIT_IDX_W+1)'(STORE_WORDS);

   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_ONE  = 2'd1;
   localparam logic [1:0] SRC_A    = 2'd2;
   localparam logic [1:0] SRC_B    = 2'd3;

   logic [WORD_W-1:0] store_a_ff [STORE_WORDS];
   logic [WORD_W-1:0] store_b_ff [STORE_WORDS];

   logic [WORD_W-1:0]  rd_a_ff;
   logic [WORD_W-1:0]  rd_b_ff;
   logic [1:0]         src_ff;
   logic [1:0]         src_in;
   logic [5:0]         pos_ff;
   logic [WORD_W-1:0]  acc_ff;
   logic [WORD_W-1:0]  acc_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               error_ff;
   logic               error_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;

   logic [BIT_IDX_W-1:0] row_ext;
   logic [BIT_IDX_W-1:0] bit_idx;
   logic [BIT_IDX_W:0]   word_ext;
   logic [BIT_IDX_W:0]   load_ext;
   logic                 rd_in_range;
   logic                 ld_in_range;
   logic [1:0]           src_sel;
   logic                 bit_val;
   logic                 out_free;

   assign row_ext     = {1'b0, req_payload.row_index};
   assign word_ext    = {7'd0, bit_idx[BIT_IDX_W-1:6]};
   assign load_ext    = {8'd0, req_payload.word_address};
   assign rd_in_range = word_ext < DEPTH;
   assign ld_in_range = load_ext < DEPTH;

   always_comb begin
      bit_idx = row_ext;
      src_sel = SRC_A;
      unique case (cfg.gather_mode)
         MODE_MERGE: begin
            if (req_payload.pick) begin
               src_sel = SRC_B;
               bit_idx = {1'b0, cfg.b_bit_offset} + row_ext;
            end
         end
         MODE_COLUMN: begin
            if (req_payload.pick) begin
               if (row_ext < cfg.column_top_rows) begin
                  src_sel = SRC_ONE;
               end
            end else begin
               src_sel = SRC_B;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      src_in   = src_sel;
      error_in = error_ff;
      if ((src_sel == SRC_A && !cfg.a_present) || (src_sel == SRC_B && !cfg.b_present)) begin
         src_in = SRC_ZERO;
      end else if ((src_sel == SRC_A || src_sel == SRC_B) && !rd_in_range) begin
         src_in = SRC_ZERO;
         if (cmd.fetch) begin
            error_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && ld_in_range) begin
         if (req_payload.store_select) begin
            store_b_ff[load_ext[AW-1:0]] <= req_payload.word_data;
         end else begin
            store_a_ff[load_ext[AW-1:0]] <= req_payload.word_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch && rd_in_range) begin
         rd_a_ff <= store_a_ff[word_ext[AW-1:0]];
         rd_b_ff <= store_b_ff[word_ext[AW-1:0]];
      end
      if (cmd.fetch) begin
         src_ff <= src_in;
         pos_ff <= bit_idx[5:0];
      end
   end

   always_comb begin
      unique case (src_ff)
         SRC_ONE:  bit_val = 1'b1;
         SRC_A:    bit_val = rd_a_ff[pos_ff];
         SRC_B:    bit_val = rd_b_ff[pos_ff];
         default:  bit_val = 1'b0;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      acc_in   = acc_ff;
      count_in = count_ff;
      if (cmd.append) begin
         acc_in[count_ff[5:0]] = bit_val;
         count_in              = count_ff + COUNT_W'(1);
      end else if (cmd.emit) begin
         acc_in   = '0;
         count_in = '0;
      end
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         count_ff     <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.packed_word <= acc_ff;
         rsp_ff.bit_count   <= count_ff;
         rsp_ff.last        <= cmd.last;
         rsp_ff.range_error <= error_ff;
      end
   end

   assign status.acc_empty     = count_ff == '0;
   assign status.acc_last_slot = count_ff == COUNT_W'(WORD_W - 1);
   assign status.out_free      = out_free;
   assign status.error         = error_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/bitmap_gather_pack_engine_top.sv
// A gather reads the bit stores in the cycle the item is accepted and appends
// the bit to the accumulator in the next; a gather that completes a 64-bit
// word then moves it into the output register through the emit state. A flush
// with bits pending moves them into the output register through the emit
// state; one with nothing pending emits nothing. A result waits in the output
// register while the next items are accepted; only an emission that finds the
// output register still stalled waits for it. Stores hold STORE_WORDS words each
// and are not cleared by reset; reading a word never loaded gives undefined bits.
// ----------------------------------------------------------------------------
// bitmap_gather_pack_engine_top
// Gathers single bits from two bit stores (or constant ones and zeros) and packs them into 64-bit words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bitmap_gather_pack_engine_top
   import bgp_pkg::*;
#(
   parameter int STORE_WORDS = STORE_WORDS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   bgp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bgp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bgp_dpath #(
      .STORE_WORDS (STORE_WORDS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `ASSERT_IMPL(a_full_word_count, clock, reset, rsp_valid && !rsp_payload.last, rsp_payload.bit_count == 7'd64)
   `ASSERT_IMPL(a_count_nonzero, clock, reset, rsp_valid, rsp_payload.bit_count != 7'd0)
   `ASSERT_NEXT(a_error_sticky, clock, reset, status.error, status.error)
   `ASSERT_IMPL(a_emit_slot_free, clock, reset, cmd.emit, status.out_free && !cmd.append)

endmodule
